// ===== src/cbrx_pkg.sv =====
// ============================================================================
// cbrx_pkg
// Shared types and protocol codes for the CAN bridge binary receive parser.
// ============================================================================
`default_nettype none

package cbrx_pkg;

    // protocol framing
    localparam logic [7:0] START_BYTE   = 8'hF1;

    // command bytes that follow the start byte
    localparam logic [7:0] CMD_FRAME    = 8'd0;
    localparam logic [7:0] CMD_SYNC     = 8'd1;
    localparam logic [7:0] CMD_DIG      = 8'd2;
    localparam logic [7:0] CMD_ANALOG   = 8'd3;
    localparam logic [7:0] CMD_NOP_A    = 8'd4;
    localparam logic [7:0] CMD_NOP_B    = 8'd5;
    localparam logic [7:0] CMD_PARAMS   = 8'd6;
    localparam logic [7:0] CMD_INFO     = 8'd7;
    localparam logic [7:0] CMD_VALIDATE = 8'd9;

    // result kinds
    localparam logic [2:0] KIND_FRAME    = 3'd0;
    localparam logic [2:0] KIND_SYNC     = 3'd1;
    localparam logic [2:0] KIND_PARAMS   = 3'd2;
    localparam logic [2:0] KIND_INFO     = 3'd3;
    localparam logic [2:0] KIND_VALIDATE = 3'd4;

    // configuration register indexes
    localparam logic CFG_ADDR_CAPTURE = 1'b0;
    localparam logic CFG_ADDR_TARGET  = 1'b1;

    // width of the packed result data bus (padded to whole bytes)
    localparam int RES_DATA_W = 232;

    typedef struct packed {
        logic        capture_enable;
        logic [31:0] target_id;
    } cfg_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] timestamp;
        logic [30:0] frame_id;
        logic        extended;
        logic [3:0]  data_len;
        logic [3:0]  bus_num;
        logic [63:0] payload;
        logic        target_hit;
        logic [31:0] baud0;
        logic [31:0] baud1;
        logic [15:0] build_number;
        logic [7:0]  single_wire;
    } result_t;

endpackage

`default_nettype wire

// ===== src/cbrx_parser.sv =====
// ============================================================================
// cbrx_parser
// Byte-wise message parser: state and field accumulators, one byte per cycle
// when byte_fire is high; a finished message's result forms in the same cycle.
// ============================================================================
`default_nettype none

module cbrx_parser
    import cbrx_pkg::*;
#(
    parameter int MAX_DATA_BYTES = 8
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       byte_fire,
    input  wire logic [7:0] rx_byte,
    input  wire cfg_t       cfg,
    output logic            res_push,
    output result_t         res
);

    localparam int IDX_W = (MAX_DATA_BYTES > 1) ? $clog2(MAX_DATA_BYTES) : 1;
    localparam logic [3:0] MAX_LEN = 4'(MAX_DATA_BYTES);

    // parser states
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_CMD    = 3'd1;
    localparam logic [2:0] ST_FRAME  = 3'd2;
    localparam logic [2:0] ST_SYNC   = 3'd3;
    localparam logic [2:0] ST_DIG    = 3'd4;
    localparam logic [2:0] ST_ANALOG = 3'd5;
    localparam logic [2:0] ST_PARAMS = 3'd6;
    localparam logic [2:0] ST_INFO   = 3'd7;

    logic [2:0]  state_reg,  state_next;
    logic [4:0]  step_reg,   step_next;
    logic [31:0] stamp_reg,  stamp_next;
    logic [30:0] ident_reg,  ident_next;
    logic        ext_reg,    ext_next;
    logic [3:0]  len_reg,    len_next;
    logic [3:0]  bus_reg,    bus_next;
    logic [7:0]  en0_reg,    en0_next;
    logic [7:0]  en1_reg,    en1_next;
    logic [31:0] baud0_reg,  baud0_next;
    logic [31:0] baud1_reg,  baud1_next;
    logic [15:0] build_reg,  build_next;
    logic [31:0] sync_reg,   sync_next;

    logic [7:0]  store_reg [MAX_DATA_BYTES];
    logic        store_we;
    logic [4:0]  store_off;
    logic [IDX_W-1:0] store_idx;

    logic [63:0] payload;
    logic        res_valid;
    logic [5:0]  data_end;
    logic [1:0]  lane0;
    logic [1:0]  lane1;

    // length nibble, clipped to the store depth
    logic [3:0]  len_nib;

    assign store_off = step_reg - 5'd9;
    assign store_idx = store_off[IDX_W-1:0];
    assign data_end  = {2'b00, len_reg} + 6'd9;
    assign lane0     = 2'(step_reg - 5'd1);
    assign lane1     = 2'(step_reg - 5'd6);
    assign len_nib   = (rx_byte[3:0] > MAX_LEN) ? MAX_LEN : rx_byte[3:0];

    // pack stored data bytes; bytes past the store depth read as zero
    for (genvar gi = 0; gi < 8; gi++) begin : g_pack
        if (gi < MAX_DATA_BYTES) begin : g_used
            assign payload[8*gi +: 8] = store_reg[gi];
        end else begin : g_zero
            assign payload[8*gi +: 8] = 8'h00;
        end
    end

    // next state, field accumulation and result forming
    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        stamp_next = stamp_reg;
        ident_next = ident_reg;
        ext_next   = ext_reg;
        len_next   = len_reg;
        bus_next   = bus_reg;
        en0_next   = en0_reg;
        en1_next   = en1_reg;
        baud0_next = baud0_reg;
        baud1_next = baud1_reg;
        build_next = build_reg;
        sync_next  = sync_reg;
        store_we   = 1'b0;
        res_valid  = 1'b0;
        res        = '0;

        case (state_reg)
            ST_IDLE: begin
                if (rx_byte == START_BYTE) begin
                    state_next = ST_CMD;
                end
            end
            ST_CMD: begin
                step_next = 5'd0;
                case (rx_byte)
                    CMD_FRAME:  state_next = ST_FRAME;
                    CMD_SYNC:   state_next = ST_SYNC;
                    CMD_DIG:    state_next = ST_DIG;
                    CMD_ANALOG: state_next = ST_ANALOG;
                    CMD_PARAMS: state_next = ST_PARAMS;
                    CMD_INFO:   state_next = ST_INFO;
                    CMD_NOP_A, CMD_NOP_B: begin
                        state_next = ST_IDLE;
                    end
                    CMD_VALIDATE: begin
                        state_next = ST_IDLE;
                        res_valid  = 1'b1;
                        res.kind   = KIND_VALIDATE;
                    end
                    default: begin
                        // unknown command: read the next byte as a command
                        step_next = step_reg;
                    end
                endcase
            end
            ST_FRAME: begin
                step_next = step_reg + 5'd1;
                if (step_reg <= 5'd3) begin
                    stamp_next[8*step_reg[1:0] +: 8] = rx_byte;
                end else if (step_reg <= 5'd6) begin
                    ident_next[8*step_reg[1:0] +: 8] = rx_byte;
                end else if (step_reg == 5'd7) begin
                    ident_next[30:24] = rx_byte[6:0];
                    ext_next          = rx_byte[7];
                end else if (step_reg == 5'd8) begin
                    len_next = len_nib;
                    bus_next = rx_byte[7:4];
                end else if ({1'b0, step_reg} < data_end) begin
                    store_we = 1'b1;
                end else begin
                    // trailer byte closes the frame
                    state_next = ST_IDLE;
                    if (cfg.capture_enable) begin
                        res_valid      = 1'b1;
                        res.kind       = KIND_FRAME;
                        res.timestamp  = stamp_reg;
                        res.frame_id   = ident_reg;
                        res.extended   = ext_reg;
                        res.data_len   = len_reg;
                        res.bus_num    = bus_reg;
                        res.payload    = payload;
                        res.target_hit = ({1'b0, ident_reg} == cfg.target_id);
                    end
                end
            end
            ST_SYNC: begin
                step_next = step_reg + 5'd1;
                sync_next[8*step_reg[1:0] +: 8] = rx_byte;
                if (step_reg >= 5'd3) begin
                    state_next    = ST_IDLE;
                    res_valid     = 1'b1;
                    res.kind      = KIND_SYNC;
                    res.timestamp = {rx_byte, sync_reg[23:0]};
                end
            end
            ST_DIG: begin
                step_next = step_reg + 5'd1;
                if (step_reg >= 5'd1) begin
                    state_next = ST_IDLE;
                end
            end
            ST_ANALOG: begin
                step_next = step_reg + 5'd1;
                if (step_reg >= 5'd8) begin
                    state_next = ST_IDLE;
                end
            end
            ST_PARAMS: begin
                step_next = step_reg + 5'd1;
                if (step_reg == 5'd0) begin
                    en0_next = rx_byte;
                end else if (step_reg <= 5'd4) begin
                    baud0_next[8*lane0 +: 8] = rx_byte;
                end else if (step_reg == 5'd5) begin
                    en1_next = rx_byte;
                end else begin
                    baud1_next[8*lane1 +: 8] = rx_byte;
                    if (step_reg >= 5'd9) begin
                        state_next = ST_IDLE;
                        res_valid  = 1'b1;
                        res.kind   = KIND_PARAMS;
                        // a disabled bus reports a zero rate
                        if (en0_reg == 8'h00) begin
                            baud0_next = '0;
                        end else begin
                            res.baud0 = baud0_reg;
                        end
                        if (en1_reg == 8'h00) begin
                            baud1_next = '0;
                        end else begin
                            res.baud1 = {rx_byte, baud1_reg[23:0]};
                        end
                    end
                end
            end
            ST_INFO: begin
                step_next = step_reg + 5'd1;
                if (step_reg == 5'd0) begin
                    build_next[7:0] = rx_byte;
                end else if (step_reg == 5'd1) begin
                    build_next[15:8] = rx_byte;
                end else if (step_reg >= 5'd5) begin
                    state_next       = ST_IDLE;
                    res_valid        = 1'b1;
                    res.kind         = KIND_INFO;
                    res.build_number = build_reg;
                    res.single_wire  = rx_byte;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign res_push = byte_fire & res_valid;

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end else if (byte_fire) begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    // field accumulators, each written before it is read
    always_ff @(posedge aclk) begin
        if (byte_fire) begin
            stamp_reg <= stamp_next;
            ident_reg <= ident_next;
            ext_reg   <= ext_next;
            len_reg   <= len_next;
            bus_reg   <= bus_next;
            en0_reg   <= en0_next;
            en1_reg   <= en1_next;
            baud0_reg <= baud0_next;
            baud1_reg <= baud1_next;
            build_reg <= build_next;
            sync_reg  <= sync_next;
        end
    end

    // data bytes; old bytes show in the payload, so they reset to zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < MAX_DATA_BYTES; i++) begin
                store_reg[i] <= 8'h00;
            end
        end else if (byte_fire && store_we) begin
            store_reg[store_idx] <= rx_byte;
        end
    end

endmodule

`default_nettype wire

// ===== src/cbrx_out_stage.sv =====
// ============================================================================
// cbrx_out_stage
// Result register with a skid entry; ready toward the parser is registered.
// ============================================================================
`default_nettype none

module cbrx_out_stage
    import cbrx_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    push,
    input  wire result_t push_data,
    output logic         push_ready,
    output logic         out_valid,
    input  wire logic    out_ready,
    output result_t      out_data
);

    logic    main_valid_reg;
    logic    skid_valid_reg;
    result_t main_reg;
    result_t skid_reg;
    logic    out_fire;

    assign out_fire   = main_valid_reg & out_ready;
    assign push_ready = ~skid_valid_reg;
    assign out_valid  = main_valid_reg;
    assign out_data   = main_reg;

    // valid flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (out_fire) begin
                skid_valid_reg <= 1'b0;
            end
        end else if (push) begin
            if (main_valid_reg && !out_fire) begin
                skid_valid_reg <= 1'b1;
            end else begin
                main_valid_reg <= 1'b1;
            end
        end else if (out_fire) begin
            main_valid_reg <= 1'b0;
        end
    end

    // result data
    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (out_fire) begin
                main_reg <= skid_reg;
            end
        end else if (push) begin
            if (main_valid_reg && !out_fire) begin
                skid_reg <= push_data;
            end else begin
                main_reg <= push_data;
            end
        end
    end

endmodule

`default_nettype wire

// ===== src/can_bridge_binary_rx_parser.sv =====
// ============================================================================
// can_bridge_binary_rx_parser
// Receive-side parser for a CAN bridge binary serial protocol: frames, time
// sync, bus parameters, device info and validation replies.
// ============================================================================
//
//  Channel   Dir  Ports                         Request
//  --------  ---  ----------------------------  ---------------------------
//  s_        in   s_tvalid s_tready s_tdata     one received byte
//  m_        out  m_tvalid m_tready m_tdata     one parsed message
//                 m_tuser                       (kind in m_tuser)
//  cfg_      in   cfg_we cfg_addr cfg_wdata     register write, no read-back
//
//  One byte is taken per cycle while s_tready is high; the result of a
//  completed message is registered as its last byte is taken and shows on m_.
//  The byte path is the parser state register plus one level of decode.
//  s_tready falls only when both the result register and its skid entry
//  are full, i.e. after m_tready has been low with a result held.
//  Reset is synchronous, active low; the first byte is taken right after.
//
`default_nettype none

module can_bridge_binary_rx_parser
    import cbrx_pkg::*;
#(
    parameter int MAX_DATA_BYTES = 8
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // input byte stream
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [7:0]            s_tdata,   // [7:0] rx_byte
    // parsed results
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // [31:0] timestamp, [62:32] frame_id, [63] extended, [67:64] data_len,
    // [71:68] bus_num, [135:72] payload, [136] target_hit, [168:137] baud0,
    // [200:169] baud1, [216:201] build_number, [224:217] single_wire,
    // [231:225] zero
    output logic [RES_DATA_W-1:0]      m_tdata,
    output logic [2:0]                 m_tuser,   // [2:0] kind
    // configuration writes
    input  wire logic                  cfg_we,
    input  wire logic                  cfg_addr,
    input  wire logic [31:0]           cfg_wdata
);

    logic    capture_reg;
    logic [31:0] target_reg;
    cfg_t    cfg;
    logic    byte_fire;
    logic    res_push;
    result_t res;
    result_t out_res;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capture_reg <= 1'b1;
            target_reg  <= '1;
        end else if (cfg_we) begin
            case (cfg_addr)
                CFG_ADDR_CAPTURE: capture_reg <= cfg_wdata[0];
                CFG_ADDR_TARGET:  target_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign cfg.capture_enable = capture_reg;
    assign cfg.target_id      = target_reg;
    assign byte_fire          = s_tvalid & s_tready;

    cbrx_parser #(
        .MAX_DATA_BYTES (MAX_DATA_BYTES)
    ) u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .byte_fire (byte_fire),
        .rx_byte   (s_tdata),
        .cfg       (cfg),
        .res_push  (res_push),
        .res       (res)
    );

    cbrx_out_stage u_out (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (res_push),
        .push_data  (res),
        .push_ready (s_tready),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_data   (out_res)
    );

    // pack result fields onto the bus
    assign m_tuser = out_res.kind;
    assign m_tdata = {7'd0,
                      out_res.single_wire,
                      out_res.build_number,
                      out_res.baud1,
                      out_res.baud0,
                      out_res.target_hit,
                      out_res.payload,
                      out_res.bus_num,
                      out_res.data_len,
                      out_res.extended,
                      out_res.frame_id,
                      out_res.timestamp};

    // ready drops only while a result is held on the output
    a_ready_needs_held: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("input stalled with no result held");

    // frame length never exceeds the data store depth
    a_len_clipped: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == KIND_FRAME) |-> (m_tdata[67:64] <= 4'(MAX_DATA_BYTES)))
        else $error("frame length above store depth");

    // target hit belongs to frames only
    a_hit_frame_only: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[136]) |-> (m_tuser == KIND_FRAME))
        else $error("target hit on a non-frame result");

    // nothing comes out in the cycle after reset
    a_reset_empty: assert property (@(posedge aclk)
        (aresetn && $past(!aresetn)) |-> !m_tvalid)
        else $error("result valid right after reset");

endmodule

`default_nettype wire

// ===== tb/rx_message_checker.sv =====
`timescale 1ns / 100ps
// ============================================================================
// rx_message_checker
// Watches the byte and message channels of the binary receive parser. It
// mirrors the parser state for each accepted byte and keeps the messages
// that are due. Each message the block hands out is compared field by field
// with the oldest one that is due.
// ============================================================================

module rx_message_checker
    import cbrx_pkg::*;
#(
    parameter int DATA_BYTES = 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [7:0]            s_tdata,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [RES_DATA_W-1:0] m_tdata,
    input  logic [2:0]            m_tuser,
    input  logic                  cfg_we,
    input  logic                  cfg_addr,
    input  logic [31:0]           cfg_wdata,
    output int                    fail_count,
    output int                    pending
);

    typedef enum logic [3:0] {
        PS_IDLE, PS_CMD, PS_FRAME, PS_SYNC, PS_DIG, PS_ANALOG, PS_PARAMS, PS_INFO
    } parse_state_e;

    // register copies
    logic        capture_on;
    logic [31:0] target_ident;

    // mirror of the parser
    parse_state_e pstate;
    int           step;
    logic [31:0]  stamp_word;
    logic [31:0]  ident_word;
    logic         ext_bit;
    logic [3:0]   len_nib;
    logic [3:0]   bus_nib;
    logic [7:0]   data_bytes [DATA_BYTES];
    logic [7:0]   en0;
    logic [7:0]   en1;
    logic [31:0]  rate0;
    logic [31:0]  rate1;
    logic [15:0]  build_word;
    logic [31:0]  sync_word;

    result_t due_messages [$];
    int      errors    = 0;
    int      msg_index = 0;

    assign fail_count = errors;

    function void clear_mirror();
        capture_on   = 1'b1;
        target_ident = 32'hFFFF_FFFF;
        pstate       = PS_IDLE;
        step         = 0;
        stamp_word   = '0;
        ident_word   = '0;
        ext_bit      = 1'b0;
        len_nib      = '0;
        bus_nib      = '0;
        for (int i = 0; i < DATA_BYTES; i++) data_bytes[i] = '0;
        en0          = '0;
        en1          = '0;
        rate0        = '0;
        rate1        = '0;
        build_word   = '0;
        sync_word    = '0;
    endfunction

    // Advance the mirror by one byte; returns 1 when a message completes.
    function bit parse_byte(input logic [7:0] b, output result_t r);
        int s;
        bit done;
        s    = step;
        done = 1'b0;
        r    = '0;
        case (pstate)
            PS_IDLE: begin
                if (b == START_BYTE) pstate = PS_CMD;
            end
            PS_CMD: begin
                case (b)
                    CMD_FRAME: begin pstate = PS_FRAME; step = 0; end
                    CMD_SYNC: begin pstate = PS_SYNC; step = 0; end
                    CMD_DIG: begin pstate = PS_DIG; step = 0; end
                    CMD_ANALOG: begin pstate = PS_ANALOG; step = 0; end
                    CMD_NOP_A, CMD_NOP_B: pstate = PS_IDLE;
                    CMD_PARAMS: begin pstate = PS_PARAMS; step = 0; end
                    CMD_INFO: begin pstate = PS_INFO; step = 0; end
                    CMD_VALIDATE: begin
                        pstate = PS_IDLE;
                        r.kind = KIND_VALIDATE;
                        done   = 1'b1;
                    end
                    // unknown command: keep reading command bytes
                    default: ;
                endcase
            end
            PS_FRAME: begin
                if (s == 0) begin
                    stamp_word = 32'(b);
                end else if (s <= 3) begin
                    stamp_word = stamp_word | (32'(b) << (8 * s));
                end else if (s == 4) begin
                    ident_word = 32'(b);
                end else if (s <= 7) begin
                    ident_word = ident_word | (32'(b) << (8 * (s - 4)));
                    if (s == 7) begin
                        ext_bit        = ident_word[31];
                        ident_word[31] = 1'b0;
                    end
                end else if (s == 8) begin
                    len_nib = (b[3:0] > DATA_BYTES) ? 4'(DATA_BYTES) : b[3:0];
                    bus_nib = b[7:4];
                end else if (s < int'(len_nib) + 9) begin
                    if (s - 9 < DATA_BYTES) data_bytes[s - 9] = b;
                end else begin
                    // trailer byte closes the frame
                    pstate = PS_IDLE;
                    if (capture_on) begin
                        r.kind      = KIND_FRAME;
                        r.timestamp = stamp_word;
                        r.frame_id  = ident_word[30:0];
                        r.extended  = ext_bit;
                        r.data_len  = len_nib;
                        r.bus_num   = bus_nib;
                        for (int i = 0; i < DATA_BYTES; i++)
                            r.payload[8*i +: 8] = data_bytes[i];
                        r.target_hit = (ident_word == target_ident);
                        done = 1'b1;
                    end
                end
                step = (s + 1) & 31;
            end
            PS_SYNC: begin
                if (s == 0) sync_word = 32'(b);
                else sync_word = sync_word | (32'(b) << (8 * (s & 3)));
                if (s >= 3) begin
                    pstate      = PS_IDLE;
                    r.kind      = KIND_SYNC;
                    r.timestamp = sync_word;
                    done        = 1'b1;
                end
                step = (s + 1) & 31;
            end
            PS_DIG: begin
                if (s >= 1) pstate = PS_IDLE;
                step = (s + 1) & 31;
            end
            PS_ANALOG: begin
                if (s >= 8) pstate = PS_IDLE;
                step = (s + 1) & 31;
            end
            PS_PARAMS: begin
                if (s == 0) begin
                    en0 = b;
                end else if (s == 1) begin
                    rate0 = 32'(b);
                end else if (s <= 4) begin
                    rate0 = rate0 | (32'(b) << (8 * (s - 1)));
                end else if (s == 5) begin
                    en1 = b;
                end else if (s == 6) begin
                    rate1 = 32'(b);
                end else begin
                    rate1 = rate1 | (32'(b) << (8 * ((s - 6) & 3)));
                    if (s >= 9) begin
                        // a disabled bus reports a zero rate
                        pstate = PS_IDLE;
                        if (en1 == 8'h00) rate1 = '0;
                        if (en0 == 8'h00) rate0 = '0;
                        r.kind  = KIND_PARAMS;
                        r.baud0 = rate0;
                        r.baud1 = rate1;
                        done    = 1'b1;
                    end
                end
                step = (s + 1) & 31;
            end
            PS_INFO: begin
                if (s == 0) begin
                    build_word = 16'(b);
                end else if (s == 1) begin
                    build_word[15:8] = b;
                end else if (s >= 5) begin
                    pstate         = PS_IDLE;
                    r.kind         = KIND_INFO;
                    r.build_number = build_word;
                    r.single_wire  = b;
                    done           = 1'b1;
                end
                step = (s + 1) & 31;
            end
            default: pstate = PS_IDLE;
        endcase
        return done;
    endfunction

    function void check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
        if (got !== want) begin
            if (errors < 10)
                $display("message %0d, %s: expected %h, got %h", msg_index, name, want,
                         got);
            errors++;
        end
    endfunction

    always @(posedge aclk) begin : watch
        result_t want;
        if (!aresetn) begin
            clear_mirror();
            due_messages.delete();
        end else begin
            // register writes
            if (cfg_we) begin
                if (cfg_addr == CFG_ADDR_CAPTURE) capture_on = cfg_wdata[0];
                else target_ident = cfg_wdata;
            end

            // accepted byte request
            if (s_tvalid && s_tready) begin
                if (parse_byte(s_tdata, want)) due_messages.push_back(want);
            end

            // accepted message request
            if (m_tvalid && m_tready) begin
                if (due_messages.size() == 0) begin
                    if (errors < 10) $display("message with none due, kind %0d", m_tuser);
                    errors++;
                end else begin
                    want = due_messages.pop_front();
                    check_field("kind", 64'(want.kind), 64'(m_tuser));
                    check_field("timestamp", 64'(want.timestamp), 64'(m_tdata[31:0]));
                    check_field("frame_id", 64'(want.frame_id), 64'(m_tdata[62:32]));
                    check_field("extended", 64'(want.extended), 64'(m_tdata[63]));
                    check_field("data_len", 64'(want.data_len), 64'(m_tdata[67:64]));
                    check_field("bus_num", 64'(want.bus_num), 64'(m_tdata[71:68]));
                    check_field("payload", want.payload, m_tdata[135:72]);
                    check_field("target_hit", 64'(want.target_hit), 64'(m_tdata[136]));
                    check_field("baud0", 64'(want.baud0), 64'(m_tdata[168:137]));
                    check_field("baud1", 64'(want.baud1), 64'(m_tdata[200:169]));
                    check_field("build_number", 64'(want.build_number),
                                64'(m_tdata[216:201]));
                    check_field("single_wire", 64'(want.single_wire),
                                64'(m_tdata[224:217]));
                    check_field("pad", 64'd0, 64'(m_tdata[RES_DATA_W-1:225]));
                    msg_index++;
                end
            end
        end
        pending <= due_messages.size();
    end

endmodule

// ===== tb/tb_can_bridge_binary_rx_parser.sv =====
`timescale 1ns / 100ps
// ============================================================================
// tb_can_bridge_binary_rx_parser
// Drives byte streams into the binary receive parser: a directed set of
// messages, special cases and register settings, then random messages in
// four flow-control phases. A checker beside the block predicts and
// compares every message; this module gives the verdict.
// ============================================================================

module tb_can_bridge_binary_rx_parser
    import cbrx_pkg::*;
();

    localparam int         DATA_BYTES    = 8;
    localparam int         STALL_LIMIT   = 5000;
    localparam int         SETTLE_CYCLES = 4;
    localparam logic [7:0] CMD_UNUSED    = 8'd8;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [RES_DATA_W-1:0] m_tdata;
    logic [2:0]            m_tuser;
    logic                  cfg_we    = 1'b0;
    logic                  cfg_addr  = 1'b0;
    logic [31:0]           cfg_wdata = '0;

    int          fail_count;
    int          pending;
    int          tx_idle_pct  = 37;
    int          rx_idle_pct  = 73;
    int          stall_cycles = 0;
    int          bytes_sent   = 0;
    logic [31:0] target_now   = 32'hFFFF_FFFF;
    logic [7:0]  msg_bytes [$];

    can_bridge_binary_rx_parser #(.MAX_DATA_BYTES(DATA_BYTES)) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    rx_message_checker #(.DATA_BYTES(DATA_BYTES)) u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .cfg_we     (cfg_we),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // 4 ns clock
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // receiver stalls
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // watchdog: too long without any accepted request
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("no progress for %0d cycles", STALL_LIMIT);
            $display("== FAIL ==");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // message builders, appending to msg_bytes
    // ------------------------------------------------------------------
    function void put_word(input logic [31:0] w);
        for (int i = 0; i < 4; i++) msg_bytes.push_back(w[8*i +: 8]);
    endfunction

    function void put_random(input int count);
        for (int i = 0; i < count; i++) msg_bytes.push_back(8'($urandom));
    endfunction

    function void put_cmd(input logic [7:0] cmd);
        msg_bytes.push_back(START_BYTE);
        msg_bytes.push_back(cmd);
    endfunction

    function void put_frame(input logic [31:0] stamp, input logic [31:0] ident,
                            input logic [7:0] len_bus, input logic [63:0] data);
        int count;
        count = (len_bus[3:0] > DATA_BYTES) ? DATA_BYTES : len_bus[3:0];
        put_cmd(CMD_FRAME);
        put_word(stamp);
        put_word(ident);
        msg_bytes.push_back(len_bus);
        for (int i = 0; i < count; i++) msg_bytes.push_back(data[8*i +: 8]);
        put_random(1);
    endfunction

    function void put_sync(input logic [31:0] basis);
        put_cmd(CMD_SYNC);
        put_word(basis);
    endfunction

    function void put_params(input logic [7:0] e0, input logic [31:0] r0,
                             input logic [7:0] e1, input logic [31:0] r1);
        put_cmd(CMD_PARAMS);
        msg_bytes.push_back(e0);
        put_word(r0);
        msg_bytes.push_back(e1);
        put_word(r1);
    endfunction

    function void put_info(input logic [15:0] build, input logic [7:0] wire_mode);
        put_cmd(CMD_INFO);
        msg_bytes.push_back(build[7:0]);
        msg_bytes.push_back(build[15:8]);
        put_random(3);
        msg_bytes.push_back(wire_mode);
    endfunction

    // mostly well-formed messages with random content, some noise
    function void put_random_message();
        int          pick;
        logic [31:0] ident;
        logic [7:0]  len_bus;
        logic [7:0]  odd_cmd;
        pick = $urandom_range(99);
        if (pick < 40) begin
            case ($urandom_range(3))
                0: ident = {1'($urandom_range(1)), target_now[30:0]};
                1: ident = 32'($urandom_range(2047));
                2: ident = {3'b100, 29'($urandom)};
                default: ident = $urandom;
            endcase
            len_bus[7:4] = 4'($urandom_range(15));
            len_bus[3:0] = ($urandom_range(4) == 0) ? 4'($urandom_range(15, 9))
                                                    : 4'($urandom_range(8));
            put_frame($urandom, ident, len_bus, {$urandom, $urandom});
        end else if (pick < 50) begin
            put_sync($urandom);
        end else if (pick < 60) begin
            put_params($urandom_range(1) ? 8'($urandom_range(255, 1)) : 8'h00, $urandom,
                       $urandom_range(1) ? 8'($urandom_range(255, 1)) : 8'h00, $urandom);
        end else if (pick < 70) begin
            put_info(16'($urandom), 8'($urandom));
        end else if (pick < 78) begin
            put_cmd(CMD_VALIDATE);
        end else if (pick < 83) begin
            put_cmd(CMD_DIG);
            put_random(2);
        end else if (pick < 88) begin
            put_cmd(CMD_ANALOG);
            put_random(9);
        end else if (pick < 92) begin
            put_cmd($urandom_range(1) ? CMD_NOP_A : CMD_NOP_B);
        end else if (pick < 96) begin
            // unknown command bytes, then a validation reply
            odd_cmd = $urandom_range(1) ? CMD_UNUSED : 8'($urandom_range(255, 10));
            put_cmd(odd_cmd);
            if ($urandom_range(1)) msg_bytes.push_back(8'($urandom_range(255, 10)));
            msg_bytes.push_back(CMD_VALIDATE);
        end else begin
            // noise or a broken start
            if ($urandom_range(1)) msg_bytes.push_back(START_BYTE);
            put_random($urandom_range(6, 1));
        end
    endfunction

    // ------------------------------------------------------------------
    // channel drivers
    // ------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic send_msg();
        while (msg_bytes.size() != 0) begin
            send_byte(msg_bytes.pop_front());
            bytes_sent++;
        end
    endtask

    // hold the sender until every due message has come out
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic configure(input logic capture, input logic [31:0] target);
        cfg_we    <= 1'b1;
        cfg_addr  <= CFG_ADDR_CAPTURE;
        cfg_wdata <= {31'd0, capture};
        @(posedge aclk);
        cfg_addr  <= CFG_ADDR_TARGET;
        cfg_wdata <= target;
        @(posedge aclk);
        cfg_we     <= 1'b0;
        target_now = target;
    endtask

    task automatic run_phase(input int tx_pct, input int rx_pct, input logic capture,
                             input logic [31:0] target, input int budget);
        int stop_at;
        drain();
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        configure(capture, target);
        stop_at = bytes_sent + budget;
        while (bytes_sent < stop_at) begin
            if ($urandom_range(99) < 3) drain();
            put_random_message();
            send_msg();
        end
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: bytes outside a message, every command, field extremes
        msg_bytes.push_back(8'h00);
        msg_bytes.push_back(8'hFF);
        put_cmd(CMD_VALIDATE);
        put_cmd(CMD_UNUSED);
        msg_bytes.push_back(START_BYTE);
        msg_bytes.push_back(CMD_VALIDATE);
        put_cmd(CMD_NOP_A);
        put_cmd(CMD_NOP_B);
        put_cmd(CMD_DIG);
        msg_bytes.push_back(8'hAA);
        msg_bytes.push_back(8'h55);
        put_cmd(CMD_ANALOG);
        put_random(9);
        put_sync(32'hFFFF_FFFF);
        put_sync(32'h0000_0000);
        put_params(8'h00, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF);
        put_params(8'h01, 32'h0007_A120, 8'h00, 32'h1234_5678);
        put_info(16'hFFFF, 8'hFF);
        put_info(16'h0000, 8'h00);
        // longest length nibble clipped to eight bytes, all ones
        put_frame(32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 64'hFFFF_FFFF_FFFF_FFFF);
        put_frame(32'h0000_0000, 32'h0000_0000, 8'h00, 64'h0);
        put_frame(32'h0102_0304, 32'h0000_07FF, 8'h39, 64'h0807_0605_0403_0201);
        // short frame: upper payload bytes keep older values
        put_frame(32'h8000_0000, 32'h1FFF_FFFF, 8'h52, 64'h0000_0000_0000_A5C3);
        send_msg();

        // target match, standard and with the extended marker set
        drain();
        configure(1'b1, 32'h0000_0000);
        put_frame($urandom, 32'h0000_0000, 8'h14, {$urandom, $urandom});
        put_frame($urandom, 32'h8000_0000, 8'h28, {$urandom, $urandom});
        send_msg();

        // capture off: frames are swallowed, other replies still come
        drain();
        configure(1'b0, 32'h7FFF_FFFF);
        put_frame($urandom, 32'h7FFF_FFFF, 8'h08, {$urandom, $urandom});
        put_sync($urandom);
        send_msg();

        drain();
        configure(1'b1, 32'h7FFF_FFFF);
        put_frame($urandom, 32'h7FFF_FFFF, 8'h03, {$urandom, $urandom});
        put_frame($urandom, 32'hFFFF_FFFF, 8'h01, {$urandom, $urandom});
        send_msg();

        // random traffic
        run_phase(37, 73, 1'b1, $urandom & 32'h7FFF_FFFF, 140);
        run_phase(73, 37, 1'b0, 32'h7FFF_FFFF, 60);
        run_phase(73, 37, 1'b1, 32'h0000_0000, 70);
        run_phase(0, 0, 1'b1, 32'hFFFF_FFFF, 130);

        drain();
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ===== files.f =====
src/cbrx_pkg.sv
src/cbrx_parser.sv
src/cbrx_out_stage.sv
src/can_bridge_binary_rx_parser.sv
tb/rx_message_checker.sv
tb/tb_can_bridge_binary_rx_parser.sv
